### rtl/core/affw_pkg.sv
// shared types, constants and codes of the affine warp block
package affw_pkg;

	// fixed field widths
	localparam int COEF_W     = 16;
	localparam int OFFS_W     = 24;
	localparam int SIZE_W     = 11;
	localparam int BASE_W     = 32;
	localparam int PIX_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// parameter defaults
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_FRAC_BITS  = 10;

	// register reset values
	localparam logic signed [COEF_W-1:0] RST_COEF_M   = 16'sd1024;
	localparam logic signed [COEF_W-1:0] RST_COEF_N   = 16'sd0;
	localparam logic signed [OFFS_W-1:0] RST_OFFSET_P = 24'sd512;
	localparam logic signed [OFFS_W-1:0] RST_OFFSET_Q = 24'sd512;
	localparam logic [SIZE_W-1:0]        RST_WIDTH    = 11'd720;
	localparam logic [SIZE_W-1:0]        RST_HEIGHT   = 11'd576;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_M       = 3'd0,
		REG_COEF_N       = 3'd1,
		REG_OFFSET_P     = 3'd2,
		REG_OFFSET_Q     = 3'd3,
		REG_FRAME_WIDTH  = 3'd4,
		REG_FRAME_HEIGHT = 3'd5
	} reg_idx_t;

	// register bank contents
	typedef struct packed {
		logic signed [COEF_W-1:0] coef_m;
		logic signed [COEF_W-1:0] coef_n;
		logic signed [OFFS_W-1:0] offset_p;
		logic signed [OFFS_W-1:0] offset_q;
		logic [SIZE_W-1:0]        frame_width;
		logic [SIZE_W-1:0]        frame_height;
	} cfg_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PROD,
		ST_SUM,
		ST_MUL,
		ST_READ,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_accept;
		logic render_accept;
		logic load_write;
		logic prod_en;
		logic sum_en;
		logic mul_en;
		logic read_en;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic item_render;
		logic out_free;
	} status_t;

endpackage

### rtl/core/affw_regs.sv
// configuration register bank of the affine warp block
module affw_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [affw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [affw_pkg::CFG_DATA_W-1:0]     cfg_data,
	output affw_pkg::cfg_t                      cfg
);
	import affw_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_m       <= RST_COEF_M;
			cfg_q.coef_n       <= RST_COEF_N;
			cfg_q.offset_p     <= RST_OFFSET_P;
			cfg_q.offset_q     <= RST_OFFSET_Q;
			cfg_q.frame_width  <= RST_WIDTH;
			cfg_q.frame_height <= RST_HEIGHT;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_COEF_M:       cfg_q.coef_m       <= cfg_data[COEF_W-1:0];
				REG_COEF_N:       cfg_q.coef_n       <= cfg_data[COEF_W-1:0];
				REG_OFFSET_P:     cfg_q.offset_p     <= cfg_data[OFFS_W-1:0];
				REG_OFFSET_Q:     cfg_q.offset_q     <= cfg_data[OFFS_W-1:0];
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data[SIZE_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/affw_ctrl.sv
// sequencing controller of the affine warp block
module affw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  affw_pkg::status_t  status,
	output affw_pkg::cmd_t     cmd
);
	import affw_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (status.item_render) begin
						cmd.render_accept = 1'b1;
						state_nxt         = ST_PROD;
					end else begin
						cmd.load_accept = 1'b1;
						state_nxt       = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				cmd.load_write = 1'b1;
				state_nxt      = ST_IDLE;
			end
			ST_PROD: begin
				cmd.prod_en = 1'b1;
				state_nxt   = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_nxt  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_nxt  = ST_READ;
			end
			ST_READ: begin
				cmd.read_en = 1'b1;
				state_nxt   = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/affw_dp.sv
// datapath of the affine warp block: raster counters, coordinate math, frame store
module affw_dp #(
	parameter int MAX_WIDTH  = affw_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = affw_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = affw_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  affw_pkg::cfg_t                cfg,
	input  affw_pkg::cmd_t                cmd,
	output affw_pkg::status_t             status,
	input  logic                          operation,
	input  logic [affw_pkg::PIX_W-1:0]    pixel_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [affw_pkg::PIX_W-1:0]    pixel_out,
	output logic                          outside,
	output logic                          frame_end
);
	import affw_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = WW + HW;
	localparam int LW    = ((WW > HW) ? WW : HW) + 1;
	localparam int SZW   = ((SIZE_W > LW) ? SIZE_W : LW) + 1;
	localparam int PW    = COEF_W + CW + 1;
	localparam int SXW   = ((PW > BASE_W) ? PW : BASE_W) + 1;
	localparam int XW    = SXW - FRAC_BITS;
	localparam int XCW   = ((XW > LW) ? XW : LW) + 1;
	localparam int YWW   = RW + WW;

	// effective frame size
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	always_comb begin
		if (cfg.frame_width == '0) begin
			w_eff = WW'(1);
		end else if (SZW'(cfg.frame_width) > SZW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg.frame_width);
		end
		if (cfg.frame_height == '0) begin
			h_eff = HW'(1);
		end else if (SZW'(cfg.frame_height) > SZW'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(cfg.frame_height);
		end
	end

	// frame size product for the load address wrap
	logic [TW-1:0] total_q;
	always_ff @(posedge clk) begin
		total_q <= w_eff * h_eff;
	end

	// load address and captured pixel
	logic [AW-1:0]    load_addr_q;
	logic [PIX_W-1:0] pix_q;
	logic [AW-1:0]    wr_addr;
	logic [TW-1:0]    wr_next;

	always_comb begin
		wr_addr = (TW'(load_addr_q) >= total_q) ? '0 : load_addr_q;
		wr_next = TW'(wr_addr) + TW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_addr_q <= '0;
		end else if (cmd.load_write) begin
			load_addr_q <= (wr_next >= total_q) ? '0 : wr_next[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_accept) begin
			pix_q <= pixel_in;
		end
	end

	// raster position and row sums
	logic [CW-1:0]            col_q;
	logic [RW-1:0]            row_q;
	logic signed [BASE_W-1:0] base_x_q;
	logic signed [BASE_W-1:0] base_y_q;
	logic                     last_q;
	logic [CW-1:0]            col_n;
	logic [RW-1:0]            row_n;
	logic [LW-1:0]            col_inc;
	logic [LW-1:0]            row_inc;
	logic                     col_wrap;
	logic                     row_wrap;

	always_comb begin
		col_n    = (LW'(col_q) >= LW'(w_eff)) ? '0 : col_q;
		row_n    = (LW'(row_q) >= LW'(h_eff)) ? '0 : row_q;
		col_inc  = LW'(col_q) + LW'(1);
		row_inc  = LW'(row_q) + LW'(1);
		col_wrap = col_inc >= LW'(w_eff);
		row_wrap = row_inc >= LW'(h_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			base_x_q <= BASE_W'(RST_OFFSET_P);
			base_y_q <= BASE_W'(RST_OFFSET_Q);
		end else if (cmd.render_accept) begin
			// restart beyond a shrunk frame, reload sums at frame start
			col_q <= col_n;
			row_q <= row_n;
			if (col_n == '0 && row_n == '0) begin
				base_x_q <= BASE_W'(cfg.offset_p);
				base_y_q <= BASE_W'(cfg.offset_q);
			end
		end else if (cmd.read_en) begin
			// step to the next output pixel
			if (col_wrap) begin
				col_q    <= '0;
				base_x_q <= base_x_q + BASE_W'(cfg.coef_n);
				base_y_q <= base_y_q + BASE_W'(cfg.coef_m);
				row_q    <= row_wrap ? '0 : row_inc[RW-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read_en) begin
			last_q <= col_wrap && row_wrap;
		end
	end

	// column products
	logic signed [PW-1:0] prod_m_s1;
	logic signed [PW-1:0] prod_n_s1;

	always_ff @(posedge clk) begin
		if (cmd.prod_en) begin
			prod_m_s1 <= cfg.coef_m * signed'({1'b0, col_q});
			prod_n_s1 <= cfg.coef_n * signed'({1'b0, col_q});
		end
	end

	// source position and bounds check
	logic signed [SXW-1:0] sx;
	logic signed [SXW-1:0] sy;
	logic signed [SXW-1:0] x_sh;
	logic signed [SXW-1:0] y_sh;
	logic                  out_calc;
	logic [CW-1:0]         x_s2;
	logic [RW-1:0]         y_s2;
	logic                  out_s2;

	always_comb begin
		sx       = SXW'(base_x_q) + SXW'(prod_m_s1);
		sy       = SXW'(base_y_q) - SXW'(prod_n_s1);
		x_sh     = sx >>> FRAC_BITS;
		y_sh     = sy >>> FRAC_BITS;
		out_calc = x_sh[SXW-1] || y_sh[SXW-1]
			|| (XCW'(x_sh[XW-1:0]) >= XCW'(w_eff))
			|| (XCW'(y_sh[XW-1:0]) >= XCW'(h_eff));
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			x_s2   <= x_sh[CW-1:0];
			y_s2   <= y_sh[RW-1:0];
			out_s2 <= out_calc;
		end
	end

	// row offset into the store
	logic [YWW-1:0] yw_s3;
	logic [CW-1:0]  x_s3;
	logic           out_s3;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			yw_s3  <= y_s2 * w_eff;
			x_s3   <= x_s2;
			out_s3 <= out_s2;
		end
	end

	// frame store, one write port and one registered read port
	logic [PIX_W-1:0] store_mem [DEPTH];
	logic [PIX_W-1:0] rdata_q;
	logic [YWW-1:0]   rd_lin;

	assign rd_lin = yw_s3 + YWW'(x_s3);

	always_ff @(posedge clk) begin
		if (cmd.load_write) begin
			store_mem[wr_addr] <= pix_q;
		end
		if (cmd.read_en && !out_s3) begin
			rdata_q <= store_mem[rd_lin[AW-1:0]];
		end
	end

	// output register
	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_out_q;
	logic             outside_q;
	logic             frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pixel_out_q <= out_s3 ? '0 : rdata_q;
			outside_q   <= out_s3;
			frame_end_q <= last_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign pixel_out          = pixel_out_q;
	assign outside            = outside_q;
	assign frame_end          = frame_end_q;
	assign status.item_render = operation;
	assign status.out_free    = !out_valid_q || out_ready;

endmodule

### rtl/core/affine_warp_nearest_q10_top.sv
// top level of the affine warp block with nearest source pixel
//
//  channel   handshake             payload
//  input     in_valid / in_ready   operation, pixel_in
//  output    out_valid / out_ready pixel_out, outside, frame_end
//  config    cfg_we                cfg_index, cfg_data
//
// a load transaction captures the pixel, then writes it into the frame store.
// a render transaction runs these steps from acceptance to the next acceptance:
// column products, position sum and bounds check, row times width product,
// store read, then the move into the output register.
// a render waits in its last step while the output register still holds an
// untaken result; no input is accepted meanwhile.
// reset clears the counters and output valid and sets the registers and row
// sums to their defaults; the frame store is not cleared and must be loaded
// before it is read.
module affine_warp_nearest_q10_top #(
	parameter int MAX_WIDTH  = affw_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = affw_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = affw_pkg::DEF_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic [affw_pkg::PIX_W-1:0]        pixel_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [affw_pkg::PIX_W-1:0]        pixel_out,
	output logic                              outside,
	output logic                              frame_end,
	input  logic                              cfg_we,
	input  logic [affw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [affw_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import affw_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	// register bank
	affw_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// controller
	affw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	affw_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.status    (status),
		.operation (operation),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.outside   (outside),
		.frame_end (frame_end)
	);

endmodule

### rtl/core/affw_checker.sv
// port level checks of the affine warp block and their binding
module affw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       operation,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] pixel_out,
	input logic       outside,
	input logic       frame_end
);

	// an outside source position always reads as black
	a_outside_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outside |-> pixel_out == 8'd0)
		else $error("outside result with nonzero pixel");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({pixel_out, outside, frame_end}))
		else $error("stalled result changed");

	// a load transaction blocks input only during its frame store write
	a_load_len: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !operation |=> !in_ready ##1 in_ready)
		else $error("load transaction length wrong");

	// a render transaction keeps input blocked through its computation steps
	a_render_len: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation
		|=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("render transaction too short");

endmodule

bind affine_warp_nearest_q10_top affw_checker u_affw_checker (.*);
